// ===== hdl/nearest_palette_color_match_macros.svh =====
`ifndef NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_MATCH_MACROS_SVH

// Property checked at every clock edge outside reset.
`define NPCM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("npcm assertion failed");

// Antecedent in one cycle, consequent in the next.
`define NPCM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npcm assertion failed");

`endif

// ===== hdl/npcm_pkg.sv =====
package npcm_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int SLOT_LIMIT            = 256;

   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int IDX_W   = 8;
   localparam int COUNT_W = 9;
   localparam int DIST_W  = 20;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int WEIGHT_W = 10;
   localparam int TERM_W  = 18;

   localparam logic [WEIGHT_W-1:0] RED_BASE  = 10'd512;
   localparam logic [WEIGHT_W-1:0] BLUE_BASE = 10'd767;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_MATCH = 1'b1;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] idx;
   } tag_type;

endpackage

// ===== hdl/npcm_dist.sv =====
module npcm_dist (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [npcm_pkg::COLOR_W-1:0]    pix,
   input  logic [npcm_pkg::COLOR_W-1:0]    entry,
   input  npcm_pkg::tag_type               tag,
   output logic [npcm_pkg::DIST_W-1:0]     distance,
   output npcm_pkg::tag_type               dist_tag
);
   import npcm_pkg::*;

   logic [CHAN_W-1:0]   r1, g1, b1, r2, g2, b2;
   logic [CHAN_W:0]     rsum;
   logic [CHAN_W-1:0]   dr, dg, db;

   logic [CHAN_W-1:0]   rmean_ff, rmean_in;
   logic [SQ_W-1:0]     drsq_ff, drsq_in, dgsq_ff, dgsq_in, dbsq_ff, dbsq_in;
   logic [WEIGHT_W-1:0] wr, wb;
   logic [WEIGHT_W+SQ_W-1:0] pr, pb;
   logic [TERM_W-1:0]   tr_ff, tr_in, tg_ff, tg_in, tb_ff, tb_in;
   logic [DIST_W-1:0]   d_ff, d_in;
   tag_type             t1_ff, t2_ff, t3_ff;

   assign {r1, g1, b1} = pix;
   assign {r2, g2, b2} = entry;

   // stage 1: differences and squares
   always_comb begin
      rsum     = {1'b0, r1} + {1'b0, r2};
      rmean_in = rsum[CHAN_W:1];
      dr       = (r1 > r2) ? r1 - r2 : r2 - r1;
      dg       = (g1 > g2) ? g1 - g2 : g2 - g1;
      db       = (b1 > b2) ? b1 - b2 : b2 - b1;
      drsq_in  = {{CHAN_W{1'b0}}, dr} * {{CHAN_W{1'b0}}, dr};
      dgsq_in  = {{CHAN_W{1'b0}}, dg} * {{CHAN_W{1'b0}}, dg};
      dbsq_in  = {{CHAN_W{1'b0}}, db} * {{CHAN_W{1'b0}}, db};
   end

   // stage 2: weighted terms
   always_comb begin
      wr    = RED_BASE + {{(WEIGHT_W-CHAN_W){1'b0}}, rmean_ff};
      wb    = BLUE_BASE - {{(WEIGHT_W-CHAN_W){1'b0}}, rmean_ff};
      pr    = {{SQ_W{1'b0}}, wr} * {{WEIGHT_W{1'b0}}, drsq_ff};
      pb    = {{SQ_W{1'b0}}, wb} * {{WEIGHT_W{1'b0}}, dbsq_ff};
      tr_in = pr[TERM_W+7:8];
      tb_in = pb[TERM_W+7:8];
      tg_in = {dgsq_ff, 2'b00};
   end

   // stage 3: sum
   assign d_in = {2'b00, tr_ff} + {2'b00, tg_ff} + {2'b00, tb_ff};

   always_ff @(posedge clock) begin
      rmean_ff <= rmean_in;
      drsq_ff  <= drsq_in;
      dgsq_ff  <= dgsq_in;
      dbsq_ff  <= dbsq_in;
      tr_ff    <= tr_in;
      tg_ff    <= tg_in;
      tb_ff    <= tb_in;
      d_ff     <= d_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t1_ff <= tag;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   assign distance = d_ff;
   assign dist_tag = t3_ff;

endmodule

// ===== hdl/nearest_palette_color_match.sv =====
// Nearest palette colour match, redmean weighted squared distance.
// req channel: tuser = func (0 load entry, 1 match pixel); tdata carries
// entry_index, red, green, blue. A load writes one palette slot and is done
// in the cycle it is taken; a load to a slot at or beyond the palette depth
// is dropped. A match scans entries 0 to count-1, one entry a cycle through
// a single pipelined distance unit fed from the palette memory read port.
// rsp channel: one transaction per match with best_index and best_distance;
// loads give none. count is palette_count with 0 taken as 1 and capped
// at the smaller of the depth and 256. rsp_tvalid rises once entry
// count-1 leaves the distance unit and the result passes through the
// WAIT and DONE states into the output register. Loads are taken at one
// a cycle while no match is in flight.
// req_tready is low while a match is in flight and returns when the result
// reaches the output register; a finished result waits there while further
// transactions are taken, and a second match result stalls until the
// receiver takes the first. csr port sets palette_count, reset value 1;
// write it only while idle. Reset clears control state and the count; the
// palette contents stay undefined until loaded.
module nearest_palette_color_match #(
   parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,  // entry_index, red, green, blue
   input  logic                         req_tuser,  // func
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,  // best_index, best_distance, zero pad
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [npcm_pkg::COUNT_W-1:0] csr_data
);
   import npcm_pkg::*;

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int LIMIT_I = (PALETTE_DEPTH < SLOT_LIMIT) ? PALETTE_DEPTH : SLOT_LIMIT;
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(LIMIT_I);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;
   logic [COLOR_W-1:0] rd_data_ff;
   tag_type            tag_m_ff, tag_m_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [DIST_W-1:0]  best_d_ff, best_d_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]  rsp_d_ff, rsp_d_in;

   logic [IDX_W-1:0]   req_index;
   logic [COLOR_W-1:0] req_color;
   logic               req_fire, load_fire, match_fire, rsp_load;
   logic               slot_ok;
   logic [AW+IDX_W-1:0] wr_ext, rd_ext;
   logic [COUNT_W-1:0] eff_count;
   logic [DIST_W-1:0]  distance;
   tag_type            dist_tag;

   assign req_index  = req_tdata[7:0];
   assign req_color  = req_tdata[31:8];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == FUNC_LOAD);
   assign match_fire = req_fire && (req_tuser == FUNC_MATCH);
   assign slot_ok    = (32'(req_index) < PALETTE_DEPTH);
   assign wr_ext     = {{AW{1'b0}}, req_index};
   assign rd_ext     = {{AW{1'b0}}, scan_ff};
   assign csr_ready  = 1'b1;

   always_comb begin
      if (count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (count_ff > LIMIT) begin
         eff_count = LIMIT;
      end else begin
         eff_count = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire && slot_ok) begin
         mem[wr_ext[AW-1:0]] <= {req_color[7:0], req_color[15:8], req_color[23:16]};
      end
      rd_data_ff <= mem[rd_ext[AW-1:0]];
   end

   npcm_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .pix      (pix_ff),
      .entry    (rd_data_ff),
      .tag      (tag_m_ff),
      .distance (distance),
      .dist_tag (dist_tag)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      last_in      = last_ff;
      pix_in       = pix_ff;
      tag_m_in     = '0;
      best_idx_in  = best_idx_ff;
      best_d_in    = best_d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_load     = 1'b0;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (dist_tag.valid && (dist_tag.idx == '0 || distance < best_d_ff)) begin
         best_idx_in = dist_tag.idx;
         best_d_in   = distance;
      end

      case (state_ff)
         ST_IDLE: begin
            if (match_fire) begin
               pix_in   = {req_color[7:0], req_color[15:8], req_color[23:16]};
               scan_in  = '0;
               last_in  = IDX_W'(eff_count - COUNT_W'(1));
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tag_m_in.valid = 1'b1;
            tag_m_in.last  = (scan_ff == last_ff);
            tag_m_in.idx   = scan_ff;
            scan_in        = scan_ff + IDX_W'(1);
            if (scan_ff == last_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (dist_tag.valid && dist_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = best_idx_ff;
         rsp_d_in     = best_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(1);
         tag_m_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tag_m_ff     <= tag_m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      last_ff     <= last_in;
      pix_ff      <= pix_in;
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_d_ff    <= rsp_d_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_d_ff, rsp_idx_ff};

endmodule

// ===== hdl/npcm_checker.sv =====
`include "nearest_palette_color_match_macros.svh"

module npcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import npcm_pkg::*;

   `NPCM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `NPCM_ASSERT_NEXT(a_match_busy, req_tvalid && req_tready && req_tuser == FUNC_MATCH, !req_tready)
   `NPCM_ASSERT_NEXT(a_load_free, req_tvalid && req_tready && req_tuser == FUNC_LOAD, req_tready)
   `NPCM_ASSERT(a_no_rsp_after_reset, $past(reset) |-> !rsp_tvalid)

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);
